// ----- src/levenshtein_nfa_step_top_assert.svh -----
`ifndef LEVENSHTEIN_NFA_STEP_TOP_ASSERT_SVH
`define LEVENSHTEIN_NFA_STEP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LEVNFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("levnfa: implication violated");

// next-cycle implication, sampled on clk, off while rst_n is low
`define LEVNFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("levnfa: next-cycle implication violated");

`endif

// ----- src/levnfa_pkg.sv -----
package levnfa_pkg;

  localparam int TERM_MAX      = 32;
  localparam int ERR_MAX       = 3;
  localparam int ROW_W         = TERM_MAX + 1;
  localparam int LEN_W         = $clog2(TERM_MAX + 1);
  localparam int K_W           = (ERR_MAX > 1) ? $clog2(ERR_MAX + 1) : 1;
  localparam int CHAR_W        = 8;
  localparam int CHAR_REGS     = 4;
  localparam int CHARS_PER_REG = 8;
  localparam int TERM_CHARS    = CHAR_REGS * CHARS_PER_REG;
  localparam int CFG_DATA_W    = CHARS_PER_REG * CHAR_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_LEN_W     = 6;
  localparam int CFG_ERR_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR  = 3'd5;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic alive;
  } out_item_t;

  typedef struct packed {
    logic [TERM_CHARS-1:0][CHAR_W-1:0] chars;
    logic [LEN_W-1:0]                  len;
    logic [K_W-1:0]                    k;
  } cfg_t;

  typedef logic [ERR_MAX:0][ROW_W-1:0] row_set_t;

endpackage

// ----- src/levnfa_cfg.sv -----
module levnfa_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [levnfa_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [levnfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output levnfa_pkg::cfg_t                    cfg
);

  logic [levnfa_pkg::CHAR_REGS-1:0][levnfa_pkg::CFG_DATA_W-1:0] term_r;
  logic [levnfa_pkg::CFG_LEN_W-1:0]                             term_length_r;
  logic [levnfa_pkg::CFG_ERR_W-1:0]                             max_errors_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r        <= '0;
      term_length_r <= '0;
      max_errors_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        levnfa_pkg::REG_TERM_0:   term_r[0]     <= cfg_wdata;
        levnfa_pkg::REG_TERM_1:   term_r[1]     <= cfg_wdata;
        levnfa_pkg::REG_TERM_2:   term_r[2]     <= cfg_wdata;
        levnfa_pkg::REG_TERM_3:   term_r[3]     <= cfg_wdata;
        levnfa_pkg::REG_TERM_LEN: term_length_r <= cfg_wdata[levnfa_pkg::CFG_LEN_W-1:0];
        levnfa_pkg::REG_MAX_ERR:  max_errors_r  <= cfg_wdata[levnfa_pkg::CFG_ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.chars = term_r;
    if (int'(term_length_r) > levnfa_pkg::TERM_MAX) begin
      cfg.len = levnfa_pkg::LEN_W'(levnfa_pkg::TERM_MAX);
    end else begin
      cfg.len = levnfa_pkg::LEN_W'(term_length_r);
    end
    if (int'(max_errors_r) > levnfa_pkg::ERR_MAX) begin
      cfg.k = levnfa_pkg::K_W'(levnfa_pkg::ERR_MAX);
    end else begin
      cfg.k = levnfa_pkg::K_W'(max_errors_r);
    end
  end

endmodule

// ----- src/levnfa_next.sv -----
module levnfa_next (
  input  levnfa_pkg::cfg_t      cfg,
  input  levnfa_pkg::in_item_t  item,
  input  levnfa_pkg::row_set_t  cur,
  output levnfa_pkg::row_set_t  nxt,
  output levnfa_pkg::out_item_t res
);

  logic [levnfa_pkg::ROW_W-1:0] le_mask;
  logic [levnfa_pkg::ROW_W-1:0] lt_mask;
  logic [levnfa_pkg::ROW_W-1:0] match;
  levnfa_pkg::row_set_t         act;

  for (genvar i = 0; i < levnfa_pkg::ROW_W; i++) begin : g_col
    assign le_mask[i] = (i <= int'(cfg.len));
    assign lt_mask[i] = (i < int'(cfg.len));
    if (i < levnfa_pkg::TERM_CHARS) begin : g_chr
      assign match[i] = (cfg.chars[i] == item.symbol);
    end else begin : g_zero
      assign match[i] = (item.symbol == '0);
    end
  end

  always_comb begin
    nxt = '0;
    act = '0;
    if (item.req_type == levnfa_pkg::REQ_RESTART) begin
      nxt[0][0] = 1'b1;
    end else begin
      for (int e = 0; e <= levnfa_pkg::ERR_MAX; e++) begin
        if (e <= int'(cfg.k)) begin
          act[e] = cur[e] & le_mask;
        end
        nxt[e] = nxt[e] | ((act[e] & match & lt_mask) << 1);
      end
      for (int e = 0; e < levnfa_pkg::ERR_MAX; e++) begin
        if (e < int'(cfg.k)) begin
          nxt[e+1] = nxt[e+1] | act[e] | ((act[e] & lt_mask) << 1);
        end
      end
    end
    // diagonal closure, row by row
    for (int e = 0; e < levnfa_pkg::ERR_MAX; e++) begin
      if (e < int'(cfg.k)) begin
        nxt[e+1] = nxt[e+1] | ((nxt[e] & lt_mask) << 1);
      end
    end
  end

  always_comb begin
    res.accepted = 1'b0;
    for (int e = 0; e <= levnfa_pkg::ERR_MAX; e++) begin
      res.accepted = res.accepted | nxt[e][cfg.len];
    end
    res.alive = |nxt;
  end

endmodule

// ----- src/levenshtein_nfa_step_top.sv -----
// An accepted transaction is registered in the input register and then in the result
// register before it is offered on out_*. Throughput: one transaction per cycle unless
// out_stall holds it back; the active-node rows are updated combinationally in between.
// Reset (rst_n low, synchronous): configuration registers clear to zero, the active
// set holds node (0,0) only, and both pipeline registers empty.
`include "levenshtein_nfa_step_top_assert.svh"

module levenshtein_nfa_step_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  levnfa_pkg::in_item_t               in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output levnfa_pkg::out_item_t              out_item,
  input  logic                               cfg_we,
  input  logic [levnfa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [levnfa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  levnfa_pkg::cfg_t      cfg;
  levnfa_pkg::in_item_t  s1_item_r;
  logic                  s1_valid_r;
  levnfa_pkg::row_set_t  active_r;
  levnfa_pkg::row_set_t  active_nxt;
  levnfa_pkg::out_item_t res_nxt;
  levnfa_pkg::out_item_t out_item_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_acc;

  levnfa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  levnfa_next u_next (
    .cfg  (cfg),
    .item (s1_item_r),
    .cur  (active_r),
    .nxt  (active_nxt),
    .res  (res_nxt)
  );

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      active_r       <= '0;
      active_r[0][0] <= 1'b1;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        active_r    <= active_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

  `LEVNFA_ASSERT_IMP(a_acc_alive, out_valid_r, !out_item_r.accepted || out_item_r.alive)
  `LEVNFA_ASSERT_IMP(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall)
  `LEVNFA_ASSERT_NXT(a_adv_out, advance, out_valid_r)
  `LEVNFA_ASSERT_NXT(a_restart, advance && s1_item_r.req_type == levnfa_pkg::REQ_RESTART,
                     active_r[0][0] && out_item_r.alive)

endmodule

// ----- tb/levenshtein_nfa_step_top_tb.sv -----
module levenshtein_nfa_step_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FREE_FLOW, SEND_GAPS, RECV_STALLS, BOTH_GAPS} traffic_mode_t;

  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 165;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [levnfa_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int LEN_PLAN [PHASES] = '{0, 1, 32, 5, 63, 3, 8, 32, 2, 16, 33, 0};
  localparam int K_PLAN [PHASES] = '{0, 3, 3, 1, 3, 2, 0, 2, 1, 3, 2, 1};
  localparam logic [7:0] ALPHA [4] = '{8'h61, 8'h62, 8'h26, 8'h23};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  levnfa_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  levnfa_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [levnfa_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [levnfa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  levenshtein_nfa_step_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] term_word [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
  logic [5:0] term_len_reg = '0;
  logic [1:0] err_bound = '0;
  levnfa_pkg::row_set_t live_rows = levnfa_pkg::row_set_t'(1);

  levnfa_pkg::in_item_t symbol_feed[$];
  levnfa_pkg::out_item_t expected_flags[$];
  traffic_mode_t mode = FREE_FLOW;
  bit holdoff_req = 1'b0;
  int errors = 0;
  int items_in = 0;
  int results_seen = 0;
  int accept_hits = 0;
  int alive_hits = 0;
  int settings_done = 0;

  function automatic int span();
    return (term_len_reg > levnfa_pkg::TERM_MAX) ? levnfa_pkg::TERM_MAX : int'(term_len_reg);
  endfunction

  function automatic logic [7:0] term_byte(int i);
    if (i >= levnfa_pkg::TERM_CHARS)
      return 8'h00;
    return term_word[i / levnfa_pkg::CHARS_PER_REG]
                    [(i % levnfa_pkg::CHARS_PER_REG) * levnfa_pkg::CHAR_W +: levnfa_pkg::CHAR_W];
  endfunction

  function automatic levnfa_pkg::out_item_t nfa_advance(levnfa_pkg::in_item_t it);
    levnfa_pkg::row_set_t nxt;
    levnfa_pkg::out_item_t flags;
    int len;
    int kk;
    nxt = '0;
    len = span();
    kk = int'(err_bound);
    if (it.req_type == levnfa_pkg::REQ_RESTART) begin
      nxt[0][0] = 1'b1;
    end else begin
      for (int e = 0; e <= kk; e++)
        for (int i = 0; i <= len; i++)
          if (live_rows[e][i]) begin
            if (i < len && term_byte(i) == it.symbol)
              nxt[e][i+1] = 1'b1;
            if (e < kk) begin
              nxt[e+1][i] = 1'b1;
              if (i < len)
                nxt[e+1][i+1] = 1'b1;
            end
          end
    end
    for (int e = 0; e < kk; e++)
      for (int i = 0; i < len; i++)
        if (nxt[e][i])
          nxt[e+1][i+1] = 1'b1;
    live_rows = nxt;
    flags.alive = |nxt;
    flags.accepted = 1'b0;
    for (int e = 0; e <= levnfa_pkg::ERR_MAX; e++)
      if (nxt[e][len])
        flags.accepted = 1'b1;
    return flags;
  endfunction

  function automatic void offer(logic req, logic [7:0] sym);
    levnfa_pkg::in_item_t it;
    it.req_type = req;
    it.symbol = sym;
    symbol_feed = {symbol_feed, it};
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (!(symbol_feed.size() == 0 && !in_valid && expected_flags.size() == 0));
  endtask

  task automatic write_reg(logic [levnfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [levnfa_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      levnfa_pkg::REG_TERM_0, levnfa_pkg::REG_TERM_1,
      levnfa_pkg::REG_TERM_2, levnfa_pkg::REG_TERM_3: term_word[idx[1:0]] = data;
      levnfa_pkg::REG_TERM_LEN: term_len_reg = data[levnfa_pkg::CFG_LEN_W-1:0];
      levnfa_pkg::REG_MAX_ERR: err_bound = data[levnfa_pkg::CFG_ERR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [3:0][63:0] words, logic [5:0] len, logic [1:0] k);
    logic [levnfa_pkg::CFG_DATA_W-1:0] data;
    drain();
    repeat (4) @(posedge clk);
    for (int i = 0; i < levnfa_pkg::CHAR_REGS; i++)
      write_reg(levnfa_pkg::REG_TERM_0 + levnfa_pkg::CFG_IDX_W'(i), words[i]);
    data = {$urandom, $urandom};
    data[levnfa_pkg::CFG_LEN_W-1:0] = len;
    write_reg(levnfa_pkg::REG_TERM_LEN, data);
    data = {$urandom, $urandom};
    data[levnfa_pkg::CFG_ERR_W-1:0] = k;
    write_reg(levnfa_pkg::REG_MAX_ERR, data);
    write_reg(REG_NONE, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  always @(posedge clk) begin : drive
    int pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_flags = {expected_flags, nfa_advance(in_item)};
        items_in++;
      end
      if (!(in_valid && in_stall)) begin
        pct = (mode == SEND_GAPS) ? 45 : (mode == BOTH_GAPS) ? 25 : 0;
        if (symbol_feed.size() > 0 && $urandom_range(0, 99) >= pct) begin
          in_item <= symbol_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    levnfa_pkg::out_item_t want;
    int pct;
    int holdoff_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      holdoff_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_flags.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual %b", $time,
                   out_item);
          errors++;
        end else begin
          want = expected_flags.pop_front();
          if (out_item.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %b, actual %b", $time,
                     want.accepted, out_item.accepted);
            errors++;
          end
          if (out_item.alive !== want.alive) begin
            $display("%0t: alive mismatch: expected %b, actual %b", $time,
                     want.alive, out_item.alive);
            errors++;
          end
          accept_hits += want.accepted;
          alive_hits += want.alive;
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (holdoff_req) begin
        holdoff_req = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
        out_stall <= 1'b1;
      end else begin
        pct = (mode == RECV_STALLS) ? 45 : (mode == BOTH_GAPS) ? 25 : 0;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0][63:0] words;
    logic [7:0] word[$];
    logic [7:0] pick;
    int len_cfg;
    int k_cfg;
    int phase_items;
    int pos;
    int n;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: empty term, no errors allowed
    offer(levnfa_pkg::REQ_CONSUME, 8'h00);
    offer(levnfa_pkg::REQ_RESTART, 8'hFF);
    offer(levnfa_pkg::REQ_CONSUME, 8'hFF);

    words = '0;
    words[0] = 64'h0000_0061_2326_FF00;
    apply_settings(words, 6'd5, 2'd2);
    offer(levnfa_pkg::REQ_RESTART, 8'h5A);
    offer(levnfa_pkg::REQ_CONSUME, 8'h00);
    offer(levnfa_pkg::REQ_CONSUME, 8'hFF);
    offer(levnfa_pkg::REQ_CONSUME, 8'h26);
    offer(levnfa_pkg::REQ_CONSUME, 8'h23);
    offer(levnfa_pkg::REQ_CONSUME, 8'h61);
    offer(levnfa_pkg::REQ_CONSUME, 8'h78);
    offer(levnfa_pkg::REQ_CONSUME, 8'h78);
    offer(levnfa_pkg::REQ_CONSUME, 8'h78);
    offer(levnfa_pkg::REQ_CONSUME, 8'h23);
    offer(levnfa_pkg::REQ_RESTART, 8'h00);
    offer(levnfa_pkg::REQ_CONSUME, 8'h61);

    // length beyond the term capacity, widest error bound
    words = {4{64'h2323_2323_2323_2323}};
    apply_settings(words, 6'd63, 2'd3);
    offer(levnfa_pkg::REQ_RESTART, 8'h00);
    offer(levnfa_pkg::REQ_CONSUME, 8'h23);
    offer(levnfa_pkg::REQ_CONSUME, 8'h26);

    for (int p = 0; p < PHASES; p++) begin
      len_cfg = (p == PHASES - 1) ? $urandom_range(1, 12) : LEN_PLAN[p];
      k_cfg = K_PLAN[p];
      for (int i = 0; i < levnfa_pkg::CHAR_REGS; i++)
        for (int b = 0; b < levnfa_pkg::CHARS_PER_REG; b++)
          words[i][b*levnfa_pkg::CHAR_W +: levnfa_pkg::CHAR_W] =
              (p % 2 == 0) ? ALPHA[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
      apply_settings(words, 6'(len_cfg), 2'(k_cfg));
      mode = traffic_mode_t'(p % 4);
      if (p == 1 || p == 6)
        holdoff_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          word.delete();
          for (int i = 0; i < span(); i++)
            word = {word, term_byte(i)};
          repeat ($urandom_range(0, int'(err_bound) + 1)) begin
            pick = $urandom_range(0, 1)
                       ? term_byte($urandom_range(0, levnfa_pkg::TERM_CHARS - 1))
                       : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
              0: if (word.size() > 0) word[$urandom_range(0, word.size() - 1)] = pick;
              1: begin
                pos = $urandom_range(0, word.size());
                word.insert(pos, pick);
              end
              default: if (word.size() > 0) word.delete($urandom_range(0, word.size() - 1));
            endcase
          end
          if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) word = {word, 8'($urandom_range(0, 255))};
          offer(levnfa_pkg::REQ_RESTART, 8'($urandom_range(0, 255)));
          foreach (word[i])
            offer(levnfa_pkg::REQ_CONSUME, word[i]);
          phase_items += word.size() + 1;
        end else begin
          n = $urandom_range(1, 8);
          repeat (n) offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          phase_items += n;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d transactions under %0d configurations, %0d results checked",
             items_in, settings_done, results_seen);
    $display("results accepting: %0d, alive: %0d; included clamped length, gaps and hold-off",
             accept_hits, alive_hits);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/levnfa_pkg.sv
src/levnfa_cfg.sv
src/levnfa_next.sv
src/levenshtein_nfa_step_top.sv
tb/levenshtein_nfa_step_top_tb.sv
